// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks for rtl, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- src/y422rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// y422rgb_pkg
// shared types, constants and arithmetic helpers of the 4:2:2 converter
// ----------------------------------------------------------------------------
package y422rgb_pkg;

	localparam int SUMW   = 22;
	localparam int CHW    = 12;
	localparam int NSTG   = 5;
	localparam int IN_W   = 32;
	localparam int OUT_W  = 64;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic REG_BYTE_ORDER  = 1'b0;
	localparam logic REG_GRAY_OUTPUT = 1'b1;

	localparam logic signed [SUMW-1:0] Y_OFS  = 22'sd16;
	localparam logic signed [SUMW-1:0] C_OFS  = 22'sd128;
	localparam logic signed [SUMW-1:0] K_Y    = 22'sd1192;
	localparam logic signed [SUMW-1:0] K_VR   = 22'sd1634;
	localparam logic signed [SUMW-1:0] K_UG   = 22'sd400;
	localparam logic signed [SUMW-1:0] K_VG   = 22'sd832;
	localparam logic signed [SUMW-1:0] K_UB   = 22'sd2065;
	localparam logic signed [SUMW-1:0] LUMA_R = 22'sd306;
	localparam logic signed [SUMW-1:0] LUMA_G = 22'sd601;
	localparam logic signed [SUMW-1:0] LUMA_B = 22'sd117;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] luma;
	} pix_t;

	typedef struct packed {
		logic byte_order;
		logic gray_output;
	} cfg_t;

	// divide by 1024, rounding toward zero
	function automatic logic signed [CHW-1:0] trunc10(input logic signed [SUMW-1:0] x);
		logic signed [SUMW-1:0] sh;
		sh = x >>> 10;
		if (x[SUMW-1] && (|x[9:0])) begin
			sh = sh + SUMW'(1);
		end
		return sh[CHW-1:0];
	endfunction

	// clamp to 0..255
	function automatic logic [7:0] sat8(input logic signed [CHW-1:0] c);
		logic [7:0] res;
		if (c[CHW-1]) begin
			res = 8'd0;
		end else if (|c[CHW-2:8]) begin
			res = 8'hFF;
		end else begin
			res = c[7:0];
		end
		return res;
	endfunction

	function automatic logic signed [SUMW-1:0] sext_ch(input logic signed [CHW-1:0] c);
		return SUMW'(c);
	endfunction

endpackage

// ----- src/packed_yuv422_to_rgb_or_gray.sv -----
// ----------------------------------------------------------------------------
// packed_yuv422_to_rgb_or_gray
// packed 4:2:2 pixel pair to two bt.601 rgb pixels or two gray levels
// ----------------------------------------------------------------------------
// pipeline: matrix products, channel sums, clamp and luma weights, pixel register, output word
// throughput: one pixel pair per cycle while the output is not stalled, two lanes run side by side
// stall: each stage holds only while the stage after it is full and stalled
// reset: arst_n clears the stage valid bits and both registers to 0
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module packed_yuv422_to_rgb_or_gray import y422rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// byte_a, byte_b, byte_c, byte_d
	input  logic [IN_W-1:0]   s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// red_first, green_first, blue_first, red_second, green_second,
	// blue_second, luma_first, luma_second
	output logic [OUT_W-1:0]  m_axis_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t            cfg;
	logic [NSTG-1:0] valid_q;
	logic [NSTG-1:0] adv;
	stage_en_t       en;
	logic [7:0]      y0, y1, u, v;
	pix_t            pix_first, pix_second;

	y422rgb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// a stage moves when it is empty or the next one moves
	always_comb begin
		adv[NSTG-1] = !valid_q[NSTG-1] || m_axis_tready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= s_axis_tvalid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign en.s1 = adv[0];
	assign en.s2 = adv[1];
	assign en.s3 = adv[2];
	assign en.s4 = adv[3];
	assign en.s5 = adv[4];

	assign s_axis_tready = adv[0];
	assign m_axis_tvalid = valid_q[NSTG-1];

	// unpack per byte order
	always_comb begin
		if (cfg.byte_order) begin
			y0 = s_axis_tdata[7:0];
			u  = s_axis_tdata[15:8];
			y1 = s_axis_tdata[23:16];
			v  = s_axis_tdata[31:24];
		end else begin
			u  = s_axis_tdata[7:0];
			y0 = s_axis_tdata[15:8];
			v  = s_axis_tdata[23:16];
			y1 = s_axis_tdata[31:24];
		end
	end

	y422rgb_lane u_lane_first (
		.clk     (clk),
		.luma_in (y0),
		.u_in    (u),
		.v_in    (v),
		.en      (en),
		.pix     (pix_first)
	);

	y422rgb_lane u_lane_second (
		.clk     (clk),
		.luma_in (y1),
		.u_in    (u),
		.v_in    (v),
		.en      (en),
		.pix     (pix_second)
	);

	y422rgb_merge u_merge (
		.clk         (clk),
		.pix_first   (pix_first),
		.pix_second  (pix_second),
		.gray_output (cfg.gray_output),
		.en          (en),
		.tdata       (m_axis_tdata)
	);

	`ASSERT_IMPLY(a_stall_full, clk, arst_n, !s_axis_tready, valid_q == '1, "input stalled with a free stage")
	`ASSERT_NEXT(a_in_taken, clk, arst_n, s_axis_tvalid && s_axis_tready, valid_q[0], "input transfer not captured")
	`ASSERT_NEXT(a_mid_hold, clk, arst_n, valid_q[3] && !adv[4], valid_q[3], "stalled item lost in pipeline")
	`ASSERT_NEXT(a_out_drain, clk, arst_n, m_axis_tvalid && m_axis_tready && !valid_q[3], !m_axis_tvalid, "output transfer repeated")

endmodule

// ----- src/y422rgb_lane.sv -----
// ----------------------------------------------------------------------------
// y422rgb_lane
// one pixel: bt.601 matrix, truncating divide, clamp and luma weighting
// ----------------------------------------------------------------------------
module y422rgb_lane import y422rgb_pkg::*; (
	input  logic       clk,
	input  logic [7:0] luma_in,
	input  logic [7:0] u_in,
	input  logic [7:0] v_in,
	input  stage_en_t  en,
	output pix_t       pix
);

	logic signed [SUMW-1:0] ye, ue, ve;
	logic signed [SUMW-1:0] ys_s1, vr_s1, ug_s1, vg_s1, ub_s1;
	logic signed [CHW-1:0]  r_s2, g_s2, b_s2;
	logic [7:0]             r_s3, g_s3, b_s3;
	logic signed [SUMW-1:0] pr_s3, pg_s3, pb_s3;
	pix_t                   pix_s4;

	assign ye = SUMW'(signed'({1'b0, luma_in})) - Y_OFS;
	assign ue = SUMW'(signed'({1'b0, u_in})) - C_OFS;
	assign ve = SUMW'(signed'({1'b0, v_in})) - C_OFS;

	// matrix products
	always_ff @(posedge clk) begin
		if (en.s1) begin
			ys_s1 <= ye * K_Y;
			vr_s1 <= ve * K_VR;
			ug_s1 <= ue * K_UG;
			vg_s1 <= ve * K_VG;
			ub_s1 <= ue * K_UB;
		end
	end

	// channel sums, scaled down
	always_ff @(posedge clk) begin
		if (en.s2) begin
			r_s2 <= trunc10(ys_s1 + vr_s1);
			g_s2 <= trunc10(ys_s1 - ug_s1 - vg_s1);
			b_s2 <= trunc10(ys_s1 + ub_s1);
		end
	end

	// clamped channels and luma weights
	always_ff @(posedge clk) begin
		if (en.s3) begin
			r_s3  <= sat8(r_s2);
			g_s3  <= sat8(g_s2);
			b_s3  <= sat8(b_s2);
			pr_s3 <= sext_ch(r_s2) * LUMA_R;
			pg_s3 <= sext_ch(g_s2) * LUMA_G;
			pb_s3 <= sext_ch(b_s2) * LUMA_B;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			pix_s4.r    <= r_s3;
			pix_s4.g    <= g_s3;
			pix_s4.b    <= b_s3;
			pix_s4.luma <= sat8(trunc10(pr_s3 + pg_s3 + pb_s3));
		end
	end

	assign pix = pix_s4;

endmodule

// ----- src/y422rgb_merge.sv -----
// ----------------------------------------------------------------------------
// y422rgb_merge
// combines both lanes into the output word, rgb pair or gray pair
// ----------------------------------------------------------------------------
module y422rgb_merge import y422rgb_pkg::*; (
	input  logic             clk,
	input  pix_t             pix_first,
	input  pix_t             pix_second,
	input  logic             gray_output,
	input  stage_en_t        en,
	output logic [OUT_W-1:0] tdata
);

	logic [OUT_W-1:0] tdata_s5;

	always_ff @(posedge clk) begin
		if (en.s5) begin
			if (gray_output) begin
				tdata_s5 <= {pix_second.luma, pix_first.luma, 48'd0};
			end else begin
				tdata_s5 <= {16'd0, pix_second.b, pix_second.g, pix_second.r,
					pix_first.b, pix_first.g, pix_first.r};
			end
		end
	end

	assign tdata = tdata_s5;

endmodule

// ----- src/y422rgb_cfg.sv -----
// ----------------------------------------------------------------------------
// y422rgb_cfg
// apb register file: byte order and output mode
// ----------------------------------------------------------------------------
module y422rgb_cfg import y422rgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic byte_order_q;
	logic gray_output_q;
	logic idx;
	logic wr;

	assign pready = 1'b1;
	assign idx    = paddr[2];
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q  <= 1'b0;
			gray_output_q <= 1'b0;
		end else if (wr) begin
			case (idx)
				REG_BYTE_ORDER:  byte_order_q  <= pwdata[0];
				REG_GRAY_OUTPUT: gray_output_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BYTE_ORDER:  prdata = {{(DATA_W-1){1'b0}}, byte_order_q};
			REG_GRAY_OUTPUT: prdata = {{(DATA_W-1){1'b0}}, gray_output_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.byte_order  = byte_order_q;
	assign cfg.gray_output = gray_output_q;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the packed 4:2:2 to rgb or gray converter: a table
// of directed pixel pairs and then random pairs are pushed over the input
// stream under every byte order and output mode, each accepted pair is run
// through an independent bt.601 fixed-point model, and every output transfer
// is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb import y422rgb_pkg::*;;

	localparam int CHUNK      = 104;
	localparam int LONG_HOLD  = 200;
	localparam int SETTLE     = 8;
	localparam int TAIL       = 20;
	localparam int CYCLE_CAP  = 400000;
	localparam int N_ROWS     = 19;

	typedef struct packed {
		logic             order;
		logic             gray;
		logic             typed;
		logic [IN_W-1:0]  word;
		logic [OUT_W-1:0] want;
	} row_t;

	// word bytes from low: byte_a, byte_b, byte_c, byte_d
	localparam row_t PAIR_TABLE [N_ROWS] = '{
		'{1'b0, 1'b0, 1'b1, 32'hEB80_1080, 64'h0000_FEFE_FE00_0000},
		'{1'b0, 1'b0, 1'b1, 32'h0000_0000, 64'h0000_0087_0000_8700},
		'{1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 64'h0000_FF7D_FFFF_7DFF},
		'{1'b0, 1'b0, 1'b0, 32'h00FF_FF00, 64'h0},
		'{1'b0, 1'b0, 1'b0, 32'hFF00_00FF, 64'h0},
		'{1'b0, 1'b0, 1'b0, 32'h807F_1180, 64'h0},
		'{1'b0, 1'b0, 1'b0, 32'h1234_5678, 64'h0},
		'{1'b0, 1'b1, 1'b1, 32'h0000_0000, 64'h0},
		'{1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 64'hFFFF_0000_0000_0000},
		'{1'b0, 1'b1, 1'b1, 32'hEB80_1080, 64'hFE00_0000_0000_0000},
		'{1'b0, 1'b1, 1'b0, 32'h00FF_FF00, 64'h0},
		'{1'b0, 1'b1, 1'b0, 32'h807F_1180, 64'h0},
		'{1'b1, 1'b1, 1'b1, 32'h80EB_8010, 64'hFE00_0000_0000_0000},
		'{1'b1, 1'b1, 1'b0, 32'hFF00_FF00, 64'h0},
		'{1'b1, 1'b1, 1'b0, 32'h00FF_00FF, 64'h0},
		'{1'b1, 1'b0, 1'b1, 32'h80EB_8010, 64'h0000_FEFE_FE00_0000},
		'{1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 64'h0000_FF7D_FFFF_7DFF},
		'{1'b1, 1'b0, 1'b0, 32'h7F80_8011, 64'h0},
		'{1'b1, 1'b0, 1'b0, 32'hA5C3_3C5A, 64'h0}
	};

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic               cfg_order;
	logic               cfg_gray;
	logic [OUT_W-1:0]   pending_pairs [$];
	int                 mismatches;
	int                 cycles;
	int                 src_idle_pct;
	int                 sink_idle_pct;
	logic               hold_req;
	int                 hold_left;
	string              field_names [8] = '{"red_first", "green_first", "blue_first",
		"red_second", "green_second", "blue_second", "luma_first", "luma_second"};

	packed_yuv422_to_rgb_or_gray uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	function automatic void note_mismatch(input string what, input logic [OUT_W-1:0] want,
		input logic [OUT_W-1:0] got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("mismatch %s: expected %h, got %h", what, want, got);
		end
	endfunction

	function automatic logic [7:0] clamp_u8(input int v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

	// unclamped channels, integer division truncates toward zero
	function automatic void pixel_rgb(input int y, input int u, input int v,
		output int r, output int g, output int b);
		int ys;
		int us;
		int vs;
		ys = (y - 16) * 1192;
		us = u - 128;
		vs = v - 128;
		r = (ys + vs * 1634) / 1024;
		g = (ys - us * 400 - vs * 832) / 1024;
		b = (ys + us * 2065) / 1024;
	endfunction

	function automatic logic [7:0] gray_level(input int r, input int g, input int b);
		return clamp_u8((r * 306 + g * 601 + b * 117) / 1024);
	endfunction

	function automatic logic [OUT_W-1:0] convert_pair(input logic [IN_W-1:0] word,
		input logic order, input logic gray);
		int u;
		int y0;
		int v;
		int y1;
		int r0;
		int g0;
		int b0;
		int r1;
		int g1;
		int b1;
		logic [7:0] f [8];
		if (order) begin
			y0 = int'(word[7:0]);
			u  = int'(word[15:8]);
			y1 = int'(word[23:16]);
			v  = int'(word[31:24]);
		end else begin
			u  = int'(word[7:0]);
			y0 = int'(word[15:8]);
			v  = int'(word[23:16]);
			y1 = int'(word[31:24]);
		end
		pixel_rgb(y0, u, v, r0, g0, b0);
		pixel_rgb(y1, u, v, r1, g1, b1);
		foreach (f[k]) f[k] = 8'd0;
		if (gray) begin
			f[6] = gray_level(r0, g0, b0);
			f[7] = gray_level(r1, g1, b1);
		end else begin
			f[0] = clamp_u8(r0);
			f[1] = clamp_u8(g0);
			f[2] = clamp_u8(b0);
			f[3] = clamp_u8(r1);
			f[4] = clamp_u8(g1);
			f[5] = clamp_u8(b1);
		end
		return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
	endfunction

	function automatic logic [7:0] rand_byte();
		logic [7:0] res;
		case ($urandom_range(9))
			0: res = 8'd0;
			1: res = 8'd255;
			2: res = 8'($urandom_range(32));
			3: res = 8'($urandom_range(144, 112));
			4: res = 8'($urandom_range(255, 220));
			default: res = 8'($urandom_range(255));
		endcase
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] reg_addr(input int idx);
		return ADDR_W'(4 * idx);
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("tb failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req <= 1'b0;
			hold_left <= LONG_HOLD;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// result check first, then prediction of the pair accepted at this edge
	always @(posedge clk) begin
		logic [OUT_W-1:0] want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_pairs.size() == 0) begin
					note_mismatch("unexpected result", '0, m_axis_tdata);
				end else begin
					want = pending_pairs.pop_front();
					for (int k = 0; k < 8; k++) begin
						if (want[8*k +: 8] !== m_axis_tdata[8*k +: 8]) begin
							note_mismatch(field_names[k], OUT_W'(want[8*k +: 8]),
								OUT_W'(m_axis_tdata[8*k +: 8]));
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_pairs.push_back(convert_pair(s_axis_tdata, cfg_order, cfg_gray));
			end
		end
	end

	task automatic send_pair(input logic [IN_W-1:0] word);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_check(input logic [ADDR_W-1:0] addr, input logic want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== DATA_W'(want)) begin
			note_mismatch("register readback", OUT_W'(want), OUT_W'(prdata));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// upper data bits are random and must be ignored
	task automatic program_config(input logic order, input logic gray);
		logic [DATA_W-1:0] val;
		drain();
		val = $urandom();
		val[0] = order;
		apb_write(reg_addr(int'(REG_BYTE_ORDER)), val);
		cfg_order = order;
		val = $urandom();
		val[0] = gray;
		apb_write(reg_addr(int'(REG_GRAY_OUTPUT)), val);
		cfg_gray = gray;
		apb_check(reg_addr(int'(REG_BYTE_ORDER)), cfg_order);
		apb_check(reg_addr(int'(REG_GRAY_OUTPUT)), cfg_gray);
	endtask

	// called with the input idle; changes land between edges
	task automatic set_traffic(input int src_pct, input int sink_pct, input logic long_hold);
		@(negedge clk);
		src_idle_pct = src_pct;
		sink_idle_pct = sink_pct;
		hold_req = long_hold;
		@(posedge clk);
	endtask

	initial begin
		logic [1:0] combo;
		row_t       row;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_order = 1'b0;
		cfg_gray = 1'b0;
		mismatches = 0;
		cycles = 0;
		src_idle_pct = 32;
		sink_idle_pct = 59;
		hold_req = 1'b0;
		hold_left = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both registers come out of reset as zero
		apb_check(reg_addr(int'(REG_BYTE_ORDER)), 1'b0);
		apb_check(reg_addr(int'(REG_GRAY_OUTPUT)), 1'b0);

		for (int i = 0; i < N_ROWS; i++) begin
			row = PAIR_TABLE[i];
			if (row.order != cfg_order || row.gray != cfg_gray) begin
				program_config(row.order, row.gray);
			end
			if (row.typed && convert_pair(row.word, row.order, row.gray) !== row.want) begin
				note_mismatch("table row", row.want, convert_pair(row.word, row.order, row.gray));
			end
			send_pair(row.word);
		end

		for (int ph = 0; ph < 3; ph++) begin
			for (int ch = 0; ch < 4; ch++) begin
				combo = 2'((ch + ph) % 4);
				program_config(combo[0], combo[1]);
				case (ph)
					0: set_traffic(32, 59, ch == 0);
					1: set_traffic(59, 32, ch == 0);
					default: set_traffic(0, 0, ch == 0);
				endcase
				repeat (CHUNK) send_pair({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
